/* rtl/mtpa_pkg.sv */
// mtpa_pkg: shared constants and types for the MTPA d-axis current block.
// No dependencies.
package mtpa_pkg;

  localparam int CURRENT_WIDTH_DEF = 16;
  localparam int REG_W             = 24;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FLUX = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LD   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_LQ   = CFG_INDEX_W'(2);

  typedef struct packed {
    logic kill;  // Lq not above Ld: magnitude forced to zero
    logic flag;  // Lq equals Ld
  } mtpa_side_t;

endpackage

/* rtl/mtpa_if.sv */
// mtpa interfaces: input, result and configuration channels.
// Depends on mtpa_pkg.
interface mtpa_in_if #(parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] q_current;
  modport source (output valid, output q_current, input ready);
  modport sink   (input valid, input q_current, output ready);
endinterface

interface mtpa_out_if #(parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] d_current_target;
  logic                no_saliency;
  modport source (output valid, output d_current_target, output no_saliency, input ready);
  modport sink   (input valid, input d_current_target, input no_saliency, output ready);
endinterface

interface mtpa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mtpa_pkg::CFG_INDEX_W-1:0]    index;
  logic [mtpa_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mtpa_front.sv */
// mtpa_front: |iq|, 2*dL*|iq|, split square and radicand assembly (4 stages).
// Depends on mtpa_pkg.
module mtpa_front #(
  parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [W-1:0]                  iq,
  input  logic [mtpa_pkg::REG_W-1:0]    flux,
  input  logic [mtpa_pkg::REG_W-1:0]    ld,
  input  logic [mtpa_pkg::REG_W-1:0]    lq,
  output logic                          out_valid,
  output logic [2*(W+25)-1:0]           out_rad,
  output mtpa_pkg::mtpa_side_t          out_side
);
  import mtpa_pkg::*;

  localparam int TW   = W + 25;
  localparam int H    = (TW + 1) / 2;
  localparam int AW   = TW - H;
  localparam int RADW = 2 * TW;

  logic             v1_r, v2_r, v3_r, v4_r;
  mtpa_side_t       s1_r, s2_r, s3_r, s4_r, s1_nxt;
  logic [W-1:0]     iqa_r, iqa_nxt;
  logic [REG_W-1:0] dl_r;
  logic [TW-1:0]    t_r;
  logic [W+23:0]    prod;
  logic [47:0]      fsq2_r, fsq3_r, fsq;
  logic [2*AW-1:0]  aa_r;
  logic [TW-1:0]    ab_r;
  logic [2*H-1:0]   bb_r;
  logic [AW-1:0]    ta;
  logic [H-1:0]     tb;
  logic [RADW-1:0]  rad_r, rad_nxt;

  assign iqa_nxt     = iq[W-1] ? (~iq + W'(1)) : iq;
  assign s1_nxt.kill = !(lq > ld);
  assign s1_nxt.flag = (lq == ld);
  assign prod        = (W+24)'(dl_r) * (W+24)'(iqa_r);
  assign fsq         = 48'(flux) * 48'(flux);
  assign ta          = t_r[TW-1:H];
  assign tb          = t_r[H-1:0];
  assign rad_nxt     = {aa_r, bb_r} + (RADW'(ab_r) << (H + 1)) + (RADW'(fsq3_r) << 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iqa_r  <= iqa_nxt;
      dl_r   <= lq - ld;
      s1_r   <= s1_nxt;
      t_r    <= {prod, 1'b0};
      fsq2_r <= fsq;
      s2_r   <= s1_r;
      aa_r   <= (2*AW)'(ta) * (2*AW)'(ta);
      ab_r   <= TW'(ta) * TW'(tb);
      bb_r   <= (2*H)'(tb) * (2*H)'(tb);
      fsq3_r <= fsq2_r;
      s3_r   <= s2_r;
      rad_r  <= rad_nxt;
      s4_r   <= s3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_rad   = rad_r;
  assign out_side  = s4_r;

endmodule

/* rtl/mtpa_sqrt.sv */
// mtpa_sqrt: pipelined floor square root, one root bit per stage.
// Depends on mtpa_pkg.
module mtpa_sqrt #(
  parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2*(W+25)-1:0]      in_rad,
  input  mtpa_pkg::mtpa_side_t     in_side,
  output logic                     out_valid,
  output logic [W+24:0]            out_root,
  output mtpa_pkg::mtpa_side_t     out_side
);
  import mtpa_pkg::*;

  localparam int RW = W + 25;

  logic              v_r    [RW];
  logic [RW+1:0]     rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [2*RW-1:0]   rad_r  [RW];
  mtpa_side_t        side_r [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            v_i;
    logic [RW+1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] rad_i;
    mtpa_side_t      side_i;
    logic [RW+2:0]   remn, trial, diff;
    logic            ge;

    if (g == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_body
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign side_i = side_r[g-1];
    end

    assign remn  = {rem_i[RW:0], rad_i[2*(RW-1-g)+1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = remn - trial;
    assign ge    = (remn >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? diff[RW+1:0] : remn[RW+1:0];
        root_r[g] <= {root_i[RW-2:0], ge};
        rad_r[g]  <= rad_i;
        side_r[g] <= side_i;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

/* rtl/mtpa_div.sv */
// mtpa_div: numerator stage and pipelined restoring divide by 2*dL.
// Depends on mtpa_pkg.
module mtpa_div #(
  parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [W+24:0]                 in_root,
  input  mtpa_pkg::mtpa_side_t          in_side,
  input  logic [mtpa_pkg::REG_W-1:0]    flux,
  input  logic [mtpa_pkg::REG_W-1:0]    ld,
  input  logic [mtpa_pkg::REG_W-1:0]    lq,
  output logic                          out_valid,
  output logic [W-1:0]                  out_quot,
  output mtpa_pkg::mtpa_side_t          out_side
);
  import mtpa_pkg::*;

  localparam int RW = W + 25;

  logic [REG_W-1:0] dl;
  logic [REG_W:0]   dv;
  logic             nv_r;
  logic [RW-1:0]    num_r;
  mtpa_side_t       nside_r;

  logic             v_r    [W];
  logic [RW-1:0]    rem_r  [W];
  logic [W-1:0]     q_r    [W];
  mtpa_side_t       side_r [W];

  assign dl = lq - ld;
  assign dv = {dl, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= in_root - RW'({flux, 8'b0});
      nside_r <= in_side;
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic          v_i;
    logic [RW-1:0] rem_i;
    logic [W-1:0]  q_i;
    mtpa_side_t    side_i;
    logic [RW-1:0] sh;
    logic          ge;

    if (g == 0) begin : g_head
      assign v_i    = nv_r;
      assign rem_i  = num_r;
      assign q_i    = '0;
      assign side_i = nside_r;
    end else begin : g_body
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign q_i    = q_r[g-1];
      assign side_i = side_r[g-1];
    end

    assign sh = RW'(dv) << (W - 1 - g);
    assign ge = (rem_i >= sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? (rem_i - sh) : rem_i;
        q_r[g]    <= {q_i[W-2:0], ge};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_quot  = q_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

/* rtl/mtpa_d_axis_current_top.sv */
// MTPA d-axis current reference, top level: config registers, pipeline, output register.
// Depends on mtpa_pkg, mtpa_if, mtpa_front, mtpa_sqrt, mtpa_div.
//
// Takes one q-axis current per transfer and returns id = (F - sqrt(F^2 + 4 dL^2 iq^2))/(2 dL)
// with dL = Lq - Ld, never positive, saturated at the minimum; Lq == Ld gives 0 with
// no_saliency set, Lq < Ld gives 0. A new sample is accepted every cycle while the output is
// not stalled; the pipe is 4 front stages, CURRENT_WIDTH+25 root stages, one numerator stage,
// CURRENT_WIDTH divide stages and the output register. Back-pressure stalls the whole pipe.
// Registers may only be written while no sample is in flight.
module mtpa_d_axis_current_top #(
  parameter int CURRENT_WIDTH = mtpa_pkg::CURRENT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mtpa_in_if.sink     in_ch,
  mtpa_out_if.source  out_ch,
  mtpa_cfg_if.sink    cfg_ch
);
  import mtpa_pkg::*;

  localparam int W  = CURRENT_WIDTH;
  localparam int RW = W + 25;
  localparam logic [W-1:0] MAG_MAX = W'(1) << (W - 1);

  logic [REG_W-1:0] flux_r, ld_r, lq_r;
  logic             en;
  logic             f_v, s_v, d_v;
  logic [2*RW-1:0]  f_rad;
  logic [RW-1:0]    s_root;
  logic [W-1:0]     d_quot, mag;
  mtpa_side_t       f_side, s_side, d_side;
  logic             out_valid_r;
  logic [W-1:0]     out_d_r;
  logic             out_flag_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_r <= '0;
      ld_r   <= '0;
      lq_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FLUX: flux_r <= cfg_ch.data[REG_W-1:0];
        REG_LD:   ld_r   <= cfg_ch.data[REG_W-1:0];
        REG_LQ:   lq_r   <= cfg_ch.data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  mtpa_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid), .iq(in_ch.q_current),
    .flux(flux_r), .ld(ld_r), .lq(lq_r),
    .out_valid(f_v), .out_rad(f_rad), .out_side(f_side)
  );

  mtpa_sqrt #(.W(W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_v), .in_rad(f_rad), .in_side(f_side),
    .out_valid(s_v), .out_root(s_root), .out_side(s_side)
  );

  mtpa_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_v), .in_root(s_root), .in_side(s_side),
    .flux(flux_r), .ld(ld_r), .lq(lq_r),
    .out_valid(d_v), .out_quot(d_quot), .out_side(d_side)
  );

  assign mag = d_side.kill ? '0 : ((d_quot > MAG_MAX) ? MAG_MAX : d_quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r    <= W'(0) - mag;
      out_flag_r <= d_side.flag;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.d_current_target = out_d_r;
  assign out_ch.no_saliency      = out_flag_r;

endmodule

/* rtl/mtpa_chk.sv */
// mtpa_chk: port-level assertions for the MTPA top level, plus bind.
// Depends on mtpa_pkg and mtpa_d_axis_current_top.
module mtpa_chk #(
  parameter int W = mtpa_pkg::CURRENT_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_d,
  input logic         out_flag
);

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flag) |-> (out_d == '0))
    else $error("no_saliency set with nonzero target");

  a_not_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_d[W-1] || (out_d == '0)))
    else $error("positive d-axis target");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_d) && $stable(out_flag)))
    else $error("stalled transfer changed");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind mtpa_d_axis_current_top mtpa_chk #(.W(CURRENT_WIDTH)) u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_d(out_ch.d_current_target), .out_flag(out_ch.no_saliency)
);
